// ===== hdl/aod_pkg.sv =====
// ----------------------------------------------------------------------------
// Orientation detector package
// Shared constants, codes, types and helper functions for the accelerometer
// orientation detector.
// ----------------------------------------------------------------------------
package aod_pkg;

	// Sample history and averaging.
	localparam int HIST_DEPTH  = 4;
	localparam int SAMPLE_W    = 16;
	localparam int LIMIT_W     = 15;
	localparam int DIV         = HIST_DEPTH + 1;
	localparam int SUM_W       = SAMPLE_W + $clog2(DIV);
	localparam int MAG_W       = SUM_W;
	localparam int RECIP_SHIFT = MAG_W + $clog2(DIV) + 1;
	localparam int PROD_W      = MAG_W + RECIP_SHIFT;
	localparam logic [RECIP_SHIFT-1:0] RECIP =
		RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV));

	// Decision tick counter.
	localparam int TICK_W = 2;

	// Queue between the front and the back.
	localparam int QDEPTH = 2;
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANGE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLAT_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN       = 2'd2;

	// Configuration reset values.
	localparam logic [LIMIT_W-1:0] CHANGE_LIMIT_RST = 15'd410;
	localparam logic [LIMIT_W-1:0] FLAT_LIMIT_RST   = 15'd3686;
	localparam logic [LIMIT_W-1:0] MARGIN_RST       = 15'd410;

	// Orientation codes.
	typedef enum logic [1:0] {
		ORIENT_YPOS = 2'd0,
		ORIENT_XPOS = 2'd1,
		ORIENT_YNEG = 2'd2,
		ORIENT_XNEG = 2'd3
	} orient_t;

	// Work item handed from the front to the back.
	typedef struct packed {
		logic signed [SUM_W-1:0] sum_x;
		logic signed [SUM_W-1:0] sum_y;
		logic signed [SUM_W-1:0] sum_z;
		logic                    decide;
		orient_t                 orient;
	} work_t;

	// Queue status seen by the front, the back and the top level.
	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	// Magnitude of a signed sample, one bit wider so that the most negative
	// value is represented.
	function automatic logic [SAMPLE_W:0] mag_of(input logic signed [SAMPLE_W-1:0] v);
		logic signed [SAMPLE_W:0] w;
		w = (SAMPLE_W + 1)'(v);
		return $unsigned(v[SAMPLE_W-1] ? -w : w);
	endfunction

endpackage

// ===== hdl/aod_front.sv =====
// ----------------------------------------------------------------------------
// Orientation detector front
// Accepts samples, keeps the sample history, forms the window sums and
// classifies each sample for the orientation decision.
// ----------------------------------------------------------------------------
module aod_front
	import aod_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [LIMIT_W-1:0]         cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] raw_first,
	input  logic signed [SAMPLE_W-1:0] raw_second,
	input  logic signed [SAMPLE_W-1:0] raw_third,
	input  q_stat_t                    q_stat,
	output logic                       push,
	output work_t                      push_data
);

	logic [LIMIT_W-1:0]         change_limit_q;
	logic [LIMIT_W-1:0]         flat_limit_q;
	logic [LIMIT_W-1:0]         margin_q;
	logic signed [SAMPLE_W-1:0] hist_x_q [HIST_DEPTH];
	logic signed [SAMPLE_W-1:0] hist_y_q [HIST_DEPTH];
	logic signed [SAMPLE_W-1:0] hist_z_q [HIST_DEPTH];
	logic [TICK_W-1:0]          tick_q;
	logic [TICK_W-1:0]          tick_next;

	logic signed [SAMPLE_W-1:0] x, y, z;
	logic signed [SUM_W-1:0]    sum_x, sum_y, sum_z;
	logic [SAMPLE_W:0]          ax, ay, az;
	logic [SAMPLE_W:0]          px, py, pz;
	logic [SAMPLE_W:0]          gap;
	logic                       fast_any;
	logic                       flat;
	logic                       eval;
	orient_t                    orient;

	// Absolute difference of two magnitudes.
	function automatic logic [SAMPLE_W:0] moved(input logic [SAMPLE_W:0] a,
		input logic [SAMPLE_W:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	// The queue decouples the front from the back.
	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready;

	// The first two sensor axes are swapped on entry.
	assign x = raw_second;
	assign y = raw_first;
	assign z = raw_third;

	// Window sums over the new sample and the history.
	always_comb begin
		sum_x = SUM_W'(x);
		sum_y = SUM_W'(y);
		sum_z = SUM_W'(z);
		for (int i = 0; i < HIST_DEPTH; i++) begin
			sum_x = sum_x + SUM_W'(hist_x_q[i]);
			sum_y = sum_y + SUM_W'(hist_y_q[i]);
			sum_z = sum_z + SUM_W'(hist_z_q[i]);
		end
	end

	// Classification: motion, flat position and dominant axis.
	always_comb begin
		ax = mag_of(x);
		ay = mag_of(y);
		az = mag_of(z);
		px = mag_of(hist_x_q[0]);
		py = mag_of(hist_y_q[0]);
		pz = mag_of(hist_z_q[0]);
		fast_any = (moved(px, ax) > (SAMPLE_W + 1)'(change_limit_q)) ||
			(moved(py, ay) > (SAMPLE_W + 1)'(change_limit_q)) ||
			(moved(pz, az) > (SAMPLE_W + 1)'(change_limit_q));
		flat = az > (SAMPLE_W + 1)'(flat_limit_q);
		tick_next = tick_q + 1'b1;
		eval = (tick_next == '0);
		if (ax > ay) begin
			gap    = ax - ay;
			orient = x[SAMPLE_W-1] ? ORIENT_XNEG : ORIENT_XPOS;
		end else begin
			gap    = ay - ax;
			orient = y[SAMPLE_W-1] ? ORIENT_YNEG : ORIENT_YPOS;
		end
	end

	always_comb begin
		push_data.sum_x  = sum_x;
		push_data.sum_y  = sum_y;
		push_data.sum_z  = sum_z;
		push_data.decide = eval && !fast_any && !flat &&
			!(gap < (SAMPLE_W + 1)'(margin_q));
		push_data.orient = orient;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			change_limit_q <= CHANGE_LIMIT_RST;
			flat_limit_q   <= FLAT_LIMIT_RST;
			margin_q       <= MARGIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHANGE_LIMIT: change_limit_q <= cfg_data;
				REG_FLAT_LIMIT:   flat_limit_q   <= cfg_data;
				REG_MARGIN:       margin_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sample history delay lines and the tick counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_x_q[i] <= '0;
				hist_y_q[i] <= '0;
				hist_z_q[i] <= '0;
			end
			tick_q <= '0;
		end else if (push) begin
			for (int i = HIST_DEPTH - 1; i > 0; i--) begin
				hist_x_q[i] <= hist_x_q[i-1];
				hist_y_q[i] <= hist_y_q[i-1];
				hist_z_q[i] <= hist_z_q[i-1];
			end
			hist_x_q[0] <= x;
			hist_y_q[0] <= y;
			hist_z_q[0] <= z;
			tick_q      <= tick_next;
		end
	end

endmodule

// ===== hdl/aod_queue.sv =====
// ----------------------------------------------------------------------------
// Orientation detector queue
// Short first-in first-out queue of work items between the front and the
// back.
// ----------------------------------------------------------------------------
module aod_queue
	import aod_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  work_t   push_data,
	input  logic    pop,
	output work_t   pop_data,
	output q_stat_t stat
);

	work_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	// Pointer advance with wrap at the queue depth.
	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign stat.count = cnt_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/aod_back.sv =====
// ----------------------------------------------------------------------------
// Orientation detector back
// Divides the window sums into averages, applies the sticky orientation and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module aod_back
	import aod_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  q_stat_t                    q_stat,
	input  work_t                      pop_data,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] smooth_x,
	output logic signed [SAMPLE_W-1:0] smooth_y,
	output logic signed [SAMPLE_W-1:0] smooth_z,
	output logic [1:0]                 orientation,
	output logic                       decided
);

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] smooth_x_q, smooth_y_q, smooth_z_q;
	logic                       decided_q;
	orient_t                    orient_q;
	logic signed [SAMPLE_W-1:0] avg_x, avg_y, avg_z;

	// Division by the window length, truncating toward zero: the magnitude
	// is multiplied by a rounded-up reciprocal and the sign restored.
	function automatic logic signed [SAMPLE_W-1:0] avg_of(input logic signed [SUM_W-1:0] s);
		logic [MAG_W-1:0]    m;
		logic [PROD_W-1:0]   prod;
		logic [SAMPLE_W-1:0] q;
		m    = $unsigned(s[SUM_W-1] ? -s : s);
		prod = PROD_W'(m) * PROD_W'(RECIP);
		q    = prod[RECIP_SHIFT +: SAMPLE_W];
		return $signed(s[SUM_W-1] ? -q : q);
	endfunction

	assign avg_x = avg_of(pop_data.sum_x);
	assign avg_y = avg_of(pop_data.sum_y);
	assign avg_z = avg_of(pop_data.sum_z);

	// Take the next item when the output register is free or being emptied.
	assign pop = !q_stat.empty && (!out_valid_q || out_ready);

	assign out_valid   = out_valid_q;
	assign smooth_x    = smooth_x_q;
	assign smooth_y    = smooth_y_q;
	assign smooth_z    = smooth_z_q;
	assign orientation = orient_q;
	assign decided     = decided_q;

	// Output valid flag and sticky orientation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			orient_q    <= ORIENT_YPOS;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (pop_data.decide) begin
					orient_q <= pop_data.orient;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			smooth_x_q <= avg_x;
			smooth_y_q <= avg_y;
			smooth_z_q <= avg_z;
			decided_q  <= pop_data.decide;
		end
	end

endmodule

// ===== hdl/accel_orientation_detector.sv =====
// ----------------------------------------------------------------------------
// Accelerometer orientation detector
// Averages three-axis accelerometer samples over a five-sample window and
// tracks a sticky screen orientation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one sample per transaction, raw_first
//   and raw_second are the sensor's first two axes (taken as y and x),
//   raw_third is z, all signed with 1 g = 4096.
//   Output channel (out_valid/out_ready): one result per input transaction,
//   in order: the averages per axis, the orientation after this sample and
//   the decided flag, set when the orientation was written on this sample.
//   The block takes one sample per cycle while the queue has room. A result
//   is offered after the accepting edge writes it into the two-entry queue
//   behind the front and a later edge, once the output register is free,
//   moves it into the output register behind the divider.
//   When the receiver stalls, the output register holds its result and the
//   queue fills; in_ready falls once both queue entries are occupied.
//   Reset clears the history to zero, the tick counter and the orientation
//   to zero, loads the default limits and empties the queue and the output.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
//   next edge; index 3 is ignored.
// ----------------------------------------------------------------------------
module accel_orientation_detector
	import aod_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [LIMIT_W-1:0]         cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] raw_first,
	input  logic signed [SAMPLE_W-1:0] raw_second,
	input  logic signed [SAMPLE_W-1:0] raw_third,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] smooth_x,
	output logic signed [SAMPLE_W-1:0] smooth_y,
	output logic signed [SAMPLE_W-1:0] smooth_z,
	output logic [1:0]                 orientation,
	output logic                       decided
);

	logic    push;
	logic    pop;
	work_t   push_data;
	work_t   pop_data;
	q_stat_t q_stat;

	// Front: accept and classify.
	aod_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.raw_first  (raw_first),
		.raw_second (raw_second),
		.raw_third  (raw_third),
		.q_stat     (q_stat),
		.push       (push),
		.push_data  (push_data)
	);

	// Queue between front and back.
	aod_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// Back: divide, apply orientation, output register.
	aod_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.pop_data    (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.smooth_x    (smooth_x),
		.smooth_y    (smooth_y),
		.smooth_z    (smooth_z),
		.orientation (orientation),
		.decided     (decided)
	);

	// An accepted sample leaves at least one item in the queue.
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (q_stat.count != '0))
		else $error("queue empty right after an accepted sample");

	// A new result only appears when the queue held an item.
	a_out_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> $past(!q_stat.empty))
		else $error("result appeared without a queued item");

	// Without a decision the orientation matches the previous result.
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		($past(out_valid && out_ready) && out_valid && !decided) |->
		(orientation == $past(orientation)))
		else $error("orientation changed without a decision");

endmodule

// ===== tb/aod_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Orientation detector scoreboard
// Predicts the averaged samples and the sticky orientation for every
// accepted sample and checks the results of the detector against them in
// order.
// ----------------------------------------------------------------------------
package aod_tb_pkg;

	import aod_pkg::*;

	// One result transaction as seen on the output channel.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smooth_x;
		logic signed [SAMPLE_W-1:0] smooth_y;
		logic signed [SAMPLE_W-1:0] smooth_z;
		orient_t                    orientation;
		logic                       decided;
	} aod_result_t;

	class orientation_scoreboard;

		// Shadow of the detector state and its limits.
		int          hist_x[HIST_DEPTH];
		int          hist_y[HIST_DEPTH];
		int          hist_z[HIST_DEPTH];
		bit [TICK_W-1:0] tick;
		orient_t     orient;
		int          change_lim;
		int          flat_lim;
		int          margin_lim;

		// Results still to come, oldest first.
		aod_result_t awaited_readings[$];
		int          mismatches;

		function new();
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_x[i] = 0;
				hist_y[i] = 0;
				hist_z[i] = 0;
			end
			tick       = '0;
			orient     = ORIENT_YPOS;
			change_lim = CHANGE_LIMIT_RST;
			flat_lim   = FLAT_LIMIT_RST;
			margin_lim = MARGIN_RST;
			mismatches = 0;
		endfunction

		// A register write; indexes beyond the three limits are ignored.
		function void write_limit(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] value);
			case (idx)
				REG_CHANGE_LIMIT: change_lim = value;
				REG_FLAT_LIMIT:   flat_lim   = value;
				REG_MARGIN:       margin_lim = value;
				default: ;
			endcase
		endfunction

		function int magnitude(int v);
			return (v < 0) ? -v : v;
		endfunction

		// Work out the result of one accepted sample and queue it.
		function void note_sample(logic signed [SAMPLE_W-1:0] first,
				logic signed [SAMPLE_W-1:0] second, logic signed [SAMPLE_W-1:0] third);
			int          x;
			int          y;
			int          z;
			int          sum_x;
			int          sum_y;
			int          sum_z;
			int          ax;
			int          ay;
			bit          moving;
			aod_result_t r;
			x = second;
			y = first;
			z = third;
			sum_x = x;
			sum_y = y;
			sum_z = z;
			for (int i = 0; i < HIST_DEPTH; i++) begin
				sum_x += hist_x[i];
				sum_y += hist_y[i];
				sum_z += hist_z[i];
			end
			r.decided = 1'b0;

			// Orientation is only evaluated on every fourth sample and only
			// while the device is steady and upright.
			tick = tick + 1'b1;
			moving = magnitude(magnitude(hist_x[0]) - magnitude(x)) > change_lim ||
				magnitude(magnitude(hist_y[0]) - magnitude(y)) > change_lim ||
				magnitude(magnitude(hist_z[0]) - magnitude(z)) > change_lim;
			if (tick == '0 && !moving && !(magnitude(z) > flat_lim)) begin
				ax = magnitude(x);
				ay = magnitude(y);
				if (ax > ay) begin
					if (!(ax - ay < margin_lim)) begin
						orient    = (x < 0) ? ORIENT_XNEG : ORIENT_XPOS;
						r.decided = 1'b1;
					end
				end else begin
					if (!(ay - ax < margin_lim)) begin
						orient    = (y < 0) ? ORIENT_YNEG : ORIENT_YPOS;
						r.decided = 1'b1;
					end
				end
			end

			// Delay line, newest sample in entry zero.
			for (int i = HIST_DEPTH - 1; i > 0; i--) begin
				hist_x[i] = hist_x[i-1];
				hist_y[i] = hist_y[i-1];
				hist_z[i] = hist_z[i-1];
			end
			hist_x[0] = x;
			hist_y[0] = y;
			hist_z[0] = z;

			r.smooth_x    = SAMPLE_W'(sum_x / DIV);
			r.smooth_y    = SAMPLE_W'(sum_y / DIV);
			r.smooth_z    = SAMPLE_W'(sum_z / DIV);
			r.orientation = orient;
			awaited_readings.push_back(r);
		endfunction

		// Compare one result transaction with the oldest prediction.
		function void check_result(aod_result_t got);
			aod_result_t exp;
			if (awaited_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no sample pending: x %0d y %0d z %0d o %0d d %0d",
						$time, got.smooth_x, got.smooth_y, got.smooth_z,
						got.orientation, got.decided);
				return;
			end
			exp = awaited_readings.pop_front();
			if (got.smooth_x !== exp.smooth_x || got.smooth_y !== exp.smooth_y ||
					got.smooth_z !== exp.smooth_z || got.orientation !== exp.orientation ||
					got.decided !== exp.decided) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result mismatch", $time);
					$display("  expected x %0d y %0d z %0d o %0d d %0d",
						exp.smooth_x, exp.smooth_y, exp.smooth_z, exp.orientation, exp.decided);
					$display("  actual   x %0d y %0d z %0d o %0d d %0d",
						got.smooth_x, got.smooth_y, got.smooth_z, got.orientation, got.decided);
				end
			end
		endfunction

		function int pending();
			return awaited_readings.size();
		endfunction

	endclass

endpackage

// ===== tb/tb_accel_orientation_detector.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Orientation detector testbench
// Drives accelerometer samples through the detector under several limit
// settings, with random sender gaps and receiver stalls, and checks every
// result against a scoreboard that tracks the averages and the orientation.
// ----------------------------------------------------------------------------
module tb_accel_orientation_detector;

	import aod_pkg::*;
	import aod_tb_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int RANDOM_ITEMS   = 225;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int GROUP_LEN      = 5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [LIMIT_W-1:0]         cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] raw_first;
	logic signed [SAMPLE_W-1:0] raw_second;
	logic signed [SAMPLE_W-1:0] raw_third;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [SAMPLE_W-1:0] smooth_x;
	logic signed [SAMPLE_W-1:0] smooth_y;
	logic signed [SAMPLE_W-1:0] smooth_z;
	logic [1:0]                 orientation;
	logic                       decided;

	orientation_scoreboard sb;
	int burst_left;
	int idle_cycles = 0;
	bit hold_req;

	accel_orientation_detector i_dut (.*);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Receiver: stall density changes after spans of random length, and a long
	// hold-off is served on request.
	initial begin : receiver
		int pct;
		int span;
		pct       = 0;
		span      = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
				hold_req = 1'b0;
			end else begin
				if (span == 0) begin
					span = $urandom_range(8, 64);
					case ($urandom_range(0, 4))
						0, 1: pct = 0;
						2: pct = 25;
						3: pct = 50;
						default: pct = 85;
					endcase
				end
				span--;
				@(negedge clk);
				out_ready <= ($urandom_range(0, 99) >= pct);
			end
		end
	end

	// Output monitor and watchdog.
	always @(posedge clk) begin : out_monitor
		aod_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.smooth_x    = smooth_x;
			got.smooth_y    = smooth_y;
			got.smooth_z    = smooth_z;
			got.orientation = orient_t'(orientation);
			got.decided     = decided;
			sb.check_result(got);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Offer one sample and wait for its transaction. Samples go out in
	// bursts with random gaps between them.
	task automatic send_sample(input int first, input int second, input int third);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		in_valid   <= 1'b1;
		raw_first  <= SAMPLE_W'(first);
		raw_second <= SAMPLE_W'(second);
		raw_third  <= SAMPLE_W'(third);
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_sample(SAMPLE_W'(first), SAMPLE_W'(second), SAMPLE_W'(third));
	endtask

	task automatic send_noise();
		send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
	endtask

	// Identical samples long enough to contain at least one evaluation tick that is
	// compared against an equal previous sample.
	task automatic send_group(input int first, input int second, input int third);
		repeat (GROUP_LEN) send_sample(first, second, third);
	endtask

	function automatic int wobble(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// A device held still with small jitter; optionally one sample is
	// replaced by a random jolt.
	task automatic send_steady_run(input int len, input bit jolt);
		int bx;
		int by;
		int bz;
		int jit;
		int jolt_at;
		bx = int'($urandom_range(0, 18000)) - 9000;
		by = int'($urandom_range(0, 18000)) - 9000;
		bz = int'($urandom_range(0, 14000)) - 7000;
		// Sometimes sit close to the boundary between two orientations.
		if ($urandom_range(0, 3) == 0)
			by = (($urandom_range(0, 1) == 1) ? 1 : -1) * ((bx < 0 ? -bx : bx) + wobble(600));
		jit = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 400);
		jolt_at = jolt ? $urandom_range(0, len - 1) : -1;
		for (int k = 0; k < len; k++) begin
			if (k == jolt_at)
				send_noise();
			else
				send_sample(by + wobble(jit), bx + wobble(jit), bz + wobble(jit));
		end
	endtask

	// Mostly steady runs, some noise and some runs broken by a jolt.
	task automatic run_random(input int count);
		int sent;
		int sel;
		int len;
		sent = 0;
		while (sent < count) begin
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				len = $urandom_range(1, 12);
				send_steady_run(len, 1'b0);
			end else if (sel < 85) begin
				len = $urandom_range(1, 4);
				repeat (len) send_noise();
			end else begin
				len = $urandom_range(2, 12);
				send_steady_run(len, 1'b1);
			end
			sent += len;
		end
	endtask

	// Stop offering and wait until every result has been received.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
			input logic [LIMIT_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		sb.write_limit(idx, value);
	endtask

	task automatic apply_limits(input int change_lim, input int flat_lim, input int margin_lim);
		write_limit(REG_CHANGE_LIMIT, LIMIT_W'(change_lim));
		write_limit(REG_FLAT_LIMIT, LIMIT_W'(flat_lim));
		write_limit(REG_MARGIN, LIMIT_W'(margin_lim));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Main sequence.
	initial begin : main
		int change_set[4];
		int flat_set[4];
		int margin_set[4];
		change_set = '{0, 32767, 410, 2000};
		flat_set   = '{0, 32767, 3686, 6000};
		margin_set = '{0, 32767, 0, 100};

		sb          = new();
		burst_left  = 0;
		hold_req    = 1'b0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_CHANGE_LIMIT;
		cfg_data    = '0;
		in_valid    = 1'b0;
		raw_first   = '0;
		raw_second  = '0;
		raw_third   = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed samples under the reset limits.
		send_group(0, 4096, 0);
		send_group(-4096, 100, 0);
		send_group(4096, 0, 5000);
		send_group(1000, 1200, 0);
		for (int k = 0; k < GROUP_LEN; k++)
			send_sample(0, (k % 2 == 0) ? 8000 : 0, 0);
		send_sample(32767, -32768, -32768);
		send_sample(-32768, 32767, 32767);
		run_random(RANDOM_ITEMS);

		for (int p = 0; p < 7; p++) begin
			wait_drained();
			if (p == 0)
				write_limit(REG_SPARE, LIMIT_W'($urandom));
			if (p < 4)
				apply_limits(change_set[p], flat_set[p], margin_set[p]);
			else
				apply_limits($urandom_range(0, 1000), $urandom_range(2000, 9000),
					$urandom_range(0, 1500));

			// Largest limits: the most negative value still exceeds them.
			if (p == 1) begin
				send_group(-32768, 0, 0);
				send_group(32767, -32768, -32768);
			end
			// Zero margin: equal magnitudes fall to the y axis.
			if (p == 2) begin
				send_group(-3000, 3000, 0);
				send_group(3000, -3000, 0);
			end

			if (p == 3) begin
				// Receiver holds off while samples keep coming.
				run_random(RANDOM_ITEMS / 2);
				hold_req = 1'b1;
				run_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
			end else if (p == 4) begin
				// Sender pauses until the pipeline is empty.
				run_random(RANDOM_ITEMS / 2);
				wait_drained();
				run_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
			end else begin
				run_random(RANDOM_ITEMS);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
